// ===== rtl/sor_stencil_3d_point_assert.svh =====
// ----------------------------------------------------------------------------
// SOR stencil assertion macros
// Assertion shorthands for the SOR stencil block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SOR_STENCIL_3D_POINT_ASSERT_SVH
`define SOR_STENCIL_3D_POINT_ASSERT_SVH

`ifndef SYNTHESIS
`define SOR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sor: assertion failed");
`define SOR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sor: assertion failed");
`else
`define SOR_ASSERT_IMP(lbl, ante, cons)
`define SOR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/sor_pkg.sv =====
// ----------------------------------------------------------------------------
// SOR stencil package
// Grid geometry, arithmetic widths, command and status types.
// ----------------------------------------------------------------------------
package sor_pkg;

  localparam int SIZE_X = 16;
  localparam int SIZE_Y = 16;
  localparam int SIZE_Z = 16;
  localparam int EXT_X  = SIZE_X + 2;
  localparam int EXT_Y  = SIZE_Y + 2;
  localparam int EXT_Z  = SIZE_Z + 2;
  localparam int DEPTH  = EXT_X * EXT_Y * EXT_Z;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int POS_W   = 5;
  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int RELAX_W = 18;

  localparam logic [RELAX_W-1:0] RELAX_RESET = 18'd65536;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Accumulator starts at 3 + 3*2^35 so that the halved sum is the biased,
  // always positive dividend of the divide by three.
  localparam int SUM_W = 37;
  localparam logic [SUM_W-1:0] SUM_INIT = 37'h18_0000_0003;

  localparam int DIV_W     = SUM_W - 1;
  localparam int DIV_BITS  = 6;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam logic [2:0] DIV_BY = 3'd3;
  localparam logic [DIV_W-1:0] QUOT_BIAS = 36'h4_0000_0000;

  localparam int DIFF_W  = 35;
  localparam int DLO_W   = 17;
  localparam int DHI_W   = DIFF_W - DLO_W;
  localparam int PROD_W  = RELAX_W + 1 + DHI_W;
  localparam int RND_W   = PROD_W + DLO_W;
  localparam int RES_W   = RND_W - FRAC_W;
  localparam int SAT_W   = RES_W + 1;
  localparam logic [RND_W-1:0] RND_HALF = 54'd32768;

  localparam int CNT_W     = 3;
  localparam int NBR_READS = 7;
  localparam int NBR_LAST  = NBR_READS - 1;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_IDX_LSB = 2;
  localparam logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] REG_RELAX = 1'b0;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam pos_t POS_ONE   = pos_t'(1);
  localparam pos_t POS_TOP_X = pos_t'(SIZE_X);
  localparam pos_t POS_MAX_X = pos_t'(SIZE_X + 1);
  localparam pos_t POS_MAX_Y = pos_t'(SIZE_Y + 1);
  localparam pos_t POS_TOP_Z = pos_t'(SIZE_Z);
  localparam pos_t POS_MAX_Z = pos_t'(SIZE_Z + 1);

  typedef enum logic [3:0] {
    NB_CENTRE  = 4'd0,
    NB_XP      = 4'd1,
    NB_XM      = 4'd2,
    NB_YP      = 4'd3,
    NB_YM      = 4'd4,
    NB_ZP      = 4'd5,
    NB_ZM      = 4'd6,
    NB_WRAP_LO = 4'd7,
    NB_WRAP_HI = 4'd8
  } nbr_e;

  typedef enum logic [0:0] {
    DST_CENTRE = 1'b0,
    DST_ACC    = 1'b1
  } dst_e;

  typedef enum logic [1:0] {
    OUT_ZERO   = 2'd0,
    OUT_CENTRE = 2'd1,
    OUT_RELAX  = 2'd2
  } out_sel_e;

  localparam nbr_e NBR_ORDER [NBR_READS] = '{
    NB_CENTRE, NB_XP, NB_XM, NB_YP, NB_YM, NB_ZP, NB_ZM
  };

  typedef struct packed {
    logic     capture;
    logic     mem_we;
    logic     rd_en;
    nbr_e     nbr;
    dst_e     dst;
    logic     div_en;
    logic     div_first;
    logic     diff_en;
    logic     mul_en;
    logic     mul_hi;
    logic     round_en;
    logic     out_load;
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic in_grid;
    logic face_xhi;
    logic face_xlo;
    logic face_yhi;
    logic face_ylo;
    logic z_inner;
    logic out_full;
  } status_t;

endpackage

// ===== rtl/sor_ctrl.sv =====
// ----------------------------------------------------------------------------
// SOR stencil controller
// Sequences loads, neighbor reads, divide, multiply and result hand-off.
// ----------------------------------------------------------------------------
module sor_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sor_pkg::status_t  status_i,
  output sor_pkg::cmd_t     cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_CLASS     = 12'b0000_0000_0010,
    S_RD        = 12'b0000_0000_0100,
    S_DRAIN     = 12'b0000_0000_1000,
    S_DIV       = 12'b0000_0001_0000,
    S_DIFF      = 12'b0000_0010_0000,
    S_MUL_LO    = 12'b0000_0100_0000,
    S_MUL_HI    = 12'b0000_1000_0000,
    S_ROUND     = 12'b0001_0000_0000,
    S_FACE_WAIT = 12'b0010_0000_0000,
    S_DONE      = 12'b0100_0000_0000,
    S_SPARE     = 12'b1000_0000_0000
  } state_e;

  state_e                  state_q, state_d;
  logic [sor_pkg::CNT_W-1:0] cnt_q, cnt_d;
  sor_pkg::out_sel_e       out_sel_q, out_sel_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    out_sel_d = out_sel_q;
    cmd_o         = '0;
    cmd_o.nbr     = sor_pkg::NB_CENTRE;
    cmd_o.dst     = sor_pkg::DST_CENTRE;
    cmd_o.out_sel = out_sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CLASS;
        end
      end
      S_CLASS: begin
        if (status_i.is_load) begin
          cmd_o.mem_we = status_i.in_grid;
          state_d      = S_IDLE;
        end else if (!status_i.in_grid) begin
          out_sel_d = sor_pkg::OUT_ZERO;
          state_d   = S_DONE;
        end else if (status_i.face_xhi || status_i.face_xlo ||
                     status_i.face_yhi || status_i.face_ylo) begin
          cmd_o.rd_en = 1'b1;
          if (status_i.face_xhi) begin
            cmd_o.nbr = sor_pkg::NB_WRAP_LO;
          end else if (status_i.face_xlo) begin
            cmd_o.nbr = sor_pkg::NB_WRAP_HI;
          end else if (status_i.face_yhi) begin
            cmd_o.nbr = sor_pkg::NB_XM;
          end else begin
            cmd_o.nbr = sor_pkg::NB_CENTRE;
          end
          out_sel_d = sor_pkg::OUT_CENTRE;
          state_d   = S_FACE_WAIT;
        end else if (status_i.z_inner) begin
          cmd_o.rd_en = 1'b1;
          cnt_d       = sor_pkg::CNT_W'(1);
          out_sel_d   = sor_pkg::OUT_RELAX;
          state_d     = S_RD;
        end else begin
          out_sel_d = sor_pkg::OUT_ZERO;
          state_d   = S_DONE;
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.nbr   = sor_pkg::NBR_ORDER[cnt_q];
        cmd_o.dst   = sor_pkg::DST_ACC;
        if (cnt_q == sor_pkg::CNT_W'(sor_pkg::NBR_LAST)) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DRAIN: begin
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_en    = 1'b1;
        cmd_o.div_first = (cnt_q == '0);
        if (cnt_q == sor_pkg::CNT_W'(sor_pkg::DIV_STEPS - 1)) begin
          state_d = S_DIFF;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d       = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_hi = 1'b1;
        state_d      = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round_en = 1'b1;
        state_d        = S_DONE;
      end
      S_FACE_WAIT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_sel_q <= sor_pkg::OUT_ZERO;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_sel_q <= out_sel_d;
    end
  end

endmodule

// ===== rtl/sor_datapath.sv =====
// ----------------------------------------------------------------------------
// SOR stencil datapath
// Grid memories, neighbor accumulation, divide by six, relaxation, output.
// ----------------------------------------------------------------------------
`include "sor_stencil_3d_point_assert.svh"

module sor_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [sor_pkg::RELAX_W-1:0]         relax_i,
  input  logic                                operation_i,
  input  logic [sor_pkg::POS_W-1:0]           pos_x_i,
  input  logic [sor_pkg::POS_W-1:0]           pos_y_i,
  input  logic [sor_pkg::POS_W-1:0]           pos_z_i,
  input  logic signed [sor_pkg::DATA_W-1:0]   old_value_i,
  input  logic signed [sor_pkg::DATA_W-1:0]   rhs_value_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [sor_pkg::DATA_W-1:0]   new_value_o,
  output logic                                written_o,
  input  sor_pkg::cmd_t                       cmd_i,
  output sor_pkg::status_t                    status_o
);

  localparam int DATA_W = sor_pkg::DATA_W;
  localparam int SUM_W  = sor_pkg::SUM_W;
  localparam int DIV_W  = sor_pkg::DIV_W;
  localparam int DIV_BITS = sor_pkg::DIV_BITS;
  localparam int DIFF_W = sor_pkg::DIFF_W;
  localparam int DLO_W  = sor_pkg::DLO_W;
  localparam int DHI_W  = sor_pkg::DHI_W;
  localparam int PROD_W = sor_pkg::PROD_W;
  localparam int RND_W  = sor_pkg::RND_W;
  localparam int RES_W  = sor_pkg::RES_W;
  localparam int SAT_W  = sor_pkg::SAT_W;
  localparam int FRAC_W = sor_pkg::FRAC_W;

  logic                       op_q;
  sor_pkg::pos_t              pos_x_q, pos_y_q, pos_z_q;
  logic [DATA_W-1:0]          old_q, rhs_in_q;

  logic [DATA_W-1:0]          grid_mem [sor_pkg::DEPTH];
  logic [DATA_W-1:0]          rhs_mem  [sor_pkg::DEPTH];
  logic [DATA_W-1:0]          grid_rd_q, rhs_rd_q;
  sor_pkg::pos_t              ax, ay, az;
  sor_pkg::addr_t             addr_zy, mem_addr;

  logic                       rd_valid_q;
  sor_pkg::dst_e              rd_dst_q;

  logic signed [DATA_W-1:0]   centre_q;
  logic [SUM_W-1:0]           sum_q;

  logic [DIV_W-1:0]           div_q, div_d, div_src;
  logic [1:0]                 rem_q, rem_d, div_rem;
  logic [2:0]                 div_cur;
  logic [DIV_BITS-1:0]        div_qbits;

  logic signed [DIV_W:0]      diff_full;
  logic signed [DIFF_W-1:0]   d_q;
  logic signed [sor_pkg::RELAX_W:0] mul_a;
  logic signed [DHI_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   mul_p, p_lo_q, p_hi_q;
  logic signed [RND_W-1:0]    hi_ext, lo_ext, rnd_sum;
  logic signed [RES_W-1:0]    r_q;
  logic signed [SAT_W-1:0]    sat_sum;
  logic signed [DATA_W-1:0]   sat_val;

  logic                       out_valid_q, out_written_q;
  logic signed [DATA_W-1:0]   out_value_q;

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= operation_i;
      pos_x_q  <= pos_x_i;
      pos_y_q  <= pos_y_i;
      pos_z_q  <= pos_z_i;
      old_q    <= old_value_i;
      rhs_in_q <= rhs_value_i;
    end
  end

  always_comb begin
    status_o.is_load  = (op_q == sor_pkg::OP_LOAD);
    status_o.in_grid  = (pos_x_q <= sor_pkg::POS_MAX_X) &&
                        (pos_y_q <= sor_pkg::POS_MAX_Y) &&
                        (pos_z_q <= sor_pkg::POS_MAX_Z);
    status_o.face_xhi = (pos_x_q == sor_pkg::POS_MAX_X);
    status_o.face_xlo = (pos_x_q == '0);
    status_o.face_yhi = (pos_y_q == sor_pkg::POS_MAX_Y);
    status_o.face_ylo = (pos_y_q == '0);
    status_o.z_inner  = (pos_z_q != '0) && (pos_z_q <= sor_pkg::POS_TOP_Z);
    status_o.out_full = out_valid_q && !out_ready_i;
  end

  // Address of the selected point.
  always_comb begin
    ax = pos_x_q;
    ay = pos_y_q;
    az = pos_z_q;
    case (cmd_i.nbr)
      sor_pkg::NB_XP:      ax = pos_x_q + 1'b1;
      sor_pkg::NB_XM:      ax = pos_x_q - 1'b1;
      sor_pkg::NB_YP:      ay = pos_y_q + 1'b1;
      sor_pkg::NB_YM:      ay = pos_y_q - 1'b1;
      sor_pkg::NB_ZP:      az = pos_z_q + 1'b1;
      sor_pkg::NB_ZM:      az = pos_z_q - 1'b1;
      sor_pkg::NB_WRAP_LO: ax = sor_pkg::POS_ONE;
      sor_pkg::NB_WRAP_HI: ax = sor_pkg::POS_TOP_X;
      default:             ax = pos_x_q;
    endcase
    addr_zy  = sor_pkg::addr_t'(az) * sor_pkg::addr_t'(sor_pkg::EXT_Y)
             + sor_pkg::addr_t'(ay);
    mem_addr = addr_zy * sor_pkg::addr_t'(sor_pkg::EXT_X) + sor_pkg::addr_t'(ax);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      grid_mem[mem_addr] <= old_q;
      rhs_mem[mem_addr]  <= rhs_in_q;
    end
    grid_rd_q <= grid_mem[mem_addr];
    rhs_rd_q  <= rhs_mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      rd_dst_q   <= sor_pkg::DST_CENTRE;
    end else begin
      rd_valid_q <= cmd_i.rd_en;
      rd_dst_q   <= cmd_i.dst;
    end
  end

  // Centre read also loads the biased accumulator with 3 - 2*rhs.
  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      if (rd_dst_q == sor_pkg::DST_CENTRE) begin
        centre_q <= grid_rd_q;
        sum_q    <= sor_pkg::SUM_INIT -
                    {{(SUM_W-DATA_W-1){rhs_rd_q[DATA_W-1]}}, rhs_rd_q, 1'b0};
      end else begin
        sum_q <= sum_q + {{(SUM_W-DATA_W){grid_rd_q[DATA_W-1]}}, grid_rd_q};
      end
    end
  end

  // Divide by three, several quotient bits per cycle.
  always_comb begin
    div_src   = cmd_i.div_first ? sum_q[SUM_W-1:1] : div_q;
    div_rem   = cmd_i.div_first ? 2'b00 : rem_q;
    div_qbits = '0;
    div_cur   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      div_cur = {div_rem, div_src[DIV_W-1-i]};
      if (div_cur >= sor_pkg::DIV_BY) begin
        div_rem                 = 2'(div_cur - sor_pkg::DIV_BY);
        div_qbits[DIV_BITS-1-i] = 1'b1;
      end else begin
        div_rem = div_cur[1:0];
      end
    end
    rem_d = div_rem;
    div_d = {div_src[DIV_W-DIV_BITS-1:0], div_qbits};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_en) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
  end

  assign diff_full = $signed({1'b0, div_q}) - $signed({1'b0, sor_pkg::QUOT_BIAS})
                   - $signed({{(DIV_W+1-DATA_W){centre_q[DATA_W-1]}}, centre_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      d_q <= diff_full[DIFF_W-1:0];
    end
  end

  // One shared multiplier, low half of the difference first.
  assign mul_a = $signed({1'b0, relax_i});
  assign mul_b = cmd_i.mul_hi ? $signed(d_q[DIFF_W-1:DLO_W])
                              : $signed({1'b0, d_q[DLO_W-1:0]});
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      if (cmd_i.mul_hi) begin
        p_hi_q <= mul_p;
      end else begin
        p_lo_q <= mul_p;
      end
    end
  end

  assign hi_ext  = {p_hi_q, {DLO_W{1'b0}}};
  assign lo_ext  = {{DLO_W{p_lo_q[PROD_W-1]}}, p_lo_q};
  assign rnd_sum = hi_ext + lo_ext + $signed(sor_pkg::RND_HALF);

  always_ff @(posedge clk_i) begin
    if (cmd_i.round_en) begin
      r_q <= rnd_sum[RND_W-1:FRAC_W];
    end
  end

  always_comb begin
    sat_sum = $signed({{(SAT_W-DATA_W){centre_q[DATA_W-1]}}, centre_q})
            + $signed({r_q[RES_W-1], r_q});
    if ((&sat_sum[SAT_W-1:DATA_W-1]) || !(|sat_sum[SAT_W-1:DATA_W-1])) begin
      sat_val = sat_sum[DATA_W-1:0];
    end else if (sat_sum[SAT_W-1]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        sor_pkg::OUT_CENTRE: begin
          out_value_q   <= centre_q;
          out_written_q <= 1'b1;
        end
        sor_pkg::OUT_RELAX: begin
          out_value_q   <= sat_val;
          out_written_q <= 1'b1;
        end
        default: begin
          out_value_q   <= '0;
          out_written_q <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_value_o = out_value_q;
  assign written_o   = out_written_q;

  `SOR_ASSERT_IMP(a_div_chain, cmd_i.div_en && !cmd_i.div_first, $past(cmd_i.div_en))
  `SOR_ASSERT_IMP(a_mul_order, cmd_i.mul_en && cmd_i.mul_hi, $past(cmd_i.mul_en) && !$past(cmd_i.mul_hi))
  `SOR_ASSERT_IMP(a_out_free, cmd_i.out_load, !out_valid_q || out_ready_i)
  `SOR_ASSERT_IMP(a_port_excl, cmd_i.mem_we, !cmd_i.rd_en && !rd_valid_q)
  `SOR_ASSERT_IMP(a_div_after_reads, cmd_i.div_en, !rd_valid_q && !cmd_i.rd_en)

endmodule

// ===== rtl/sor_stencil_3d_point.sv =====
// ----------------------------------------------------------------------------
// SOR 3D seven-point stencil point engine
// Stores a Q16.16 grid with right-hand side and relaxes one point per item.
// ----------------------------------------------------------------------------
// Input items arrive on a valid/ready channel. A load item in the grid writes
// the grid and right-hand-side values of one point and returns nothing. A
// compute item returns one result item on the output valid/ready channel.
// An interior compute makes seven reads of the single-port grid memory, a
// divide by three at six bits per cycle, and two passes through one 19 by
// 18 bit multiplier.
// The relaxation factor is written through the APB port and should only be
// changed while no item is in flight. Reset clears the control logic and
// sets the factor to 1.0; the grid memories are not cleared and must be
// loaded before a point or its neighbors are computed.
// A finished result waits in an output register while the next item is
// accepted; a new result is held back until the receiver takes the old one.
// ----------------------------------------------------------------------------
module sor_stencil_3d_point (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [sor_pkg::POS_W-1:0]           pos_x_i,
  input  logic [sor_pkg::POS_W-1:0]           pos_y_i,
  input  logic [sor_pkg::POS_W-1:0]           pos_z_i,
  input  logic signed [sor_pkg::DATA_W-1:0]   old_value_i,
  input  logic signed [sor_pkg::DATA_W-1:0]   rhs_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sor_pkg::DATA_W-1:0]   new_value_o,
  output logic                                written_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sor_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [sor_pkg::RELAX_W-1:0] relax_q;
  logic                        reg_sel;
  sor_pkg::cmd_t               cmd;
  sor_pkg::status_t            status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[sor_pkg::CFG_ADDR_W-1:sor_pkg::CFG_IDX_LSB] == sor_pkg::REG_RELAX);
  assign prdata  = reg_sel ? {{(32-sor_pkg::RELAX_W){1'b0}}, relax_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q <= sor_pkg::RELAX_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      relax_q <= pwdata[sor_pkg::RELAX_W-1:0];
    end
  end

  sor_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sor_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .relax_i     (relax_q),
    .operation_i (operation_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .old_value_i (old_value_i),
    .rhs_value_i (rhs_value_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .new_value_o (new_value_o),
    .written_o   (written_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
